// ----- sv/hexpdm_pkg.sv -----
// ----------------------------------------------------------------------------
// hexpdm_pkg - shared constants for the hexacopter PD attitude mixer
// Field widths, loop gains, limits and the per-motor mixing coefficients.
// ----------------------------------------------------------------------------
package hexpdm_pkg;

  localparam int MOTOR_COUNT = 6;

  // Port widths
  localparam int STICK_W   = 16;
  localparam int ANGLE_W   = 16;
  localparam int HEIGHT_W  = 24;
  localparam int MOTOR_W   = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  // Internal widths
  localparam int ERR_W  = 29;  // largest loop error is the height error
  localparam int DIFF_W = 30;
  localparam int HEAD_W = 19;
  localparam int U_W    = 18;
  localparam int DERR_W = 32;
  localparam int OPD_W  = 33;
  localparam int ACC_W  = 64;
  localparam int PROD_W = 50;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [1:0]           axis_t;
  typedef logic signed [2:0]    coef_t;

  // Register indexes
  localparam cfg_idx_t CFG_INV_DT = 3'd0;
  localparam cfg_idx_t CFG_THRUST = 3'd1;
  localparam cfg_idx_t CFG_ROLL   = 3'd2;
  localparam cfg_idx_t CFG_PITCH  = 3'd3;
  localparam cfg_idx_t CFG_YAW    = 3'd4;

  localparam logic [CFG_W-1:0] INV_DT_RESET   = 32'd6553600;
  localparam logic [CFG_W-1:0] MIX_GAIN_RESET = 32'd65536;

  // Loop order inside the sequencer
  localparam axis_t AX_ROLL   = 2'd0;
  localparam axis_t AX_PITCH  = 2'd1;
  localparam axis_t AX_YAW    = 2'd2;
  localparam axis_t AX_HEIGHT = 2'd3;

  // PD gains, Q16.16
  localparam logic signed [OPD_W-1:0] KP_ATT = 33'sd8520;
  localparam logic signed [OPD_W-1:0] KD_ATT = 33'sd3932;
  localparam logic signed [OPD_W-1:0] KP_YAW = 33'sd9175;
  localparam logic signed [OPD_W-1:0] KD_YAW = 33'sd15729;
  localparam logic signed [OPD_W-1:0] KP_ALT = 33'sd20316;
  localparam logic signed [OPD_W-1:0] KD_ALT = 33'sd12452;

  localparam logic signed [HEAD_W-1:0] HEADING_LIMIT = 19'sd205128;
  localparam logic signed [ERR_W-1:0]  YAW_ERR_LIMIT = 29'sd205783;
  localparam logic signed [ERR_W-1:0]  YAW_ERR_FOLD  = 29'sd6554;
  localparam logic signed [ERR_W-1:0]  THR_SCALE     = 29'sd50;
  localparam logic signed [24:0]       HEAD_STEP_MUL = 25'sd131;
  localparam logic signed [24:0]       HEAD_ROUND    = 25'sd32768;

  localparam logic signed [U_W-1:0] U_MAX = 18'sd65536;
  localparam logic signed [U_W-1:0] U_MIN = -18'sd65536;

  // Twice the per-motor mixing factor of each axis
  localparam coef_t THRUST_TWICE = 3'sd2;
  localparam coef_t ROLL_TWICE  [MOTOR_COUNT] = '{3'sd0, -3'sd2, -3'sd2, 3'sd0, 3'sd2, 3'sd2};
  localparam coef_t PITCH_TWICE [MOTOR_COUNT] = '{3'sd2, 3'sd1, -3'sd1, -3'sd2, -3'sd1, 3'sd1};
  localparam coef_t YAW_TWICE   [MOTOR_COUNT] = '{-3'sd2, 3'sd2, -3'sd2, 3'sd2, -3'sd2, 3'sd2};

  // Scale a gain product by a small mixing factor with shifts only
  function automatic logic signed [ACC_W-1:0] mix_term(coef_t c,
                                                       logic signed [PROD_W-1:0] p);
    logic signed [ACC_W-1:0] v;
    v = ACC_W'(p);
    unique case (c)
      3'sd2:   return v <<< 1;
      3'sd1:   return v;
      3'sd0:   return '0;
      -3'sd1:  return -v;
      -3'sd2:  return -(v <<< 1);
      default: return '0;
    endcase
  endfunction

endpackage

// ----- sv/hexacopter_pd_attitude_mixer.sv -----
// A new input item is taken only once the previous one has been fully mixed;
// the mixer holds while the previous result is not yet taken.
// The shared 33x33 multiply-accumulate runs each PD loop as a difference,
// a kp and a kd step, then forms the gain products; the accumulator adder
// mixes each motor in pitch, roll and yaw phases. Reset clears the sequencer,
// output valid, loop history and heading, and loads the register defaults.
// ----------------------------------------------------------------------------
// hexacopter_pd_attitude_mixer - PD attitude/altitude loops and motor mixer
// Four PD loops and a six-motor mix run on one multiply-accumulate unit
// under a small sequencer.
// ----------------------------------------------------------------------------
module hexacopter_pd_attitude_mixer (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  // configuration write channel
  input  logic                                       cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  logic        [hexpdm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic        [hexpdm_pkg::CFG_W-1:0]        cfg_data_i,
  // input items
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  logic signed [hexpdm_pkg::STICK_W-1:0]      roll_stick_i,
  input  logic signed [hexpdm_pkg::STICK_W-1:0]      pitch_stick_i,
  input  logic signed [hexpdm_pkg::STICK_W-1:0]      yaw_stick_i,
  input  logic signed [hexpdm_pkg::STICK_W-1:0]      throttle_stick_i,
  input  logic signed [hexpdm_pkg::ANGLE_W-1:0]      measured_roll_i,
  input  logic signed [hexpdm_pkg::ANGLE_W-1:0]      measured_pitch_i,
  input  logic signed [hexpdm_pkg::ANGLE_W-1:0]      measured_yaw_i,
  input  logic signed [hexpdm_pkg::HEIGHT_W-1:0]     measured_height_i,
  // result items
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output logic signed [hexpdm_pkg::MOTOR_W-1:0]      motor_0_o,
  output logic signed [hexpdm_pkg::MOTOR_W-1:0]      motor_1_o,
  output logic signed [hexpdm_pkg::MOTOR_W-1:0]      motor_2_o,
  output logic signed [hexpdm_pkg::MOTOR_W-1:0]      motor_3_o,
  output logic signed [hexpdm_pkg::MOTOR_W-1:0]      motor_4_o,
  output logic signed [hexpdm_pkg::MOTOR_W-1:0]      motor_5_o
);
  import hexpdm_pkg::*;

  // Sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;  // ready for the next transfer
  localparam logic [3:0] ST_ERR  = 4'd1;  // loop errors and heading update
  localparam logic [3:0] ST_YAW  = 4'd2;  // yaw error with limit fold
  localparam logic [3:0] ST_DMUL = 4'd3;  // acc = diff * inverse_step_time
  localparam logic [3:0] ST_PMUL = 4'd4;  // latch d_error, acc = kp * error
  localparam logic [3:0] ST_DMAC = 4'd5;  // acc += kd * d_error
  localparam logic [3:0] ST_GAIN = 4'd6;  // loop output times mix gain
  localparam logic [3:0] ST_WAIT = 4'd7;  // hold until the output register is free
  localparam logic [3:0] ST_MIX  = 4'd8;  // three accumulator adds per motor
  localparam logic [3:0] ST_DONE = 4'd9;  // store last motor, raise valid

  // Mixing phases within one motor
  localparam logic [1:0] PH_PITCH = 2'd0;
  localparam logic [1:0] PH_ROLL  = 2'd1;
  localparam logic [1:0] PH_YAW   = 2'd2;

  localparam logic [2:0] MOTOR_LAST = 3'(MOTOR_COUNT - 1);

  localparam logic signed [DERR_W-1:0]  DERR_MAX  = {1'b0, {(DERR_W-1){1'b1}}};
  localparam logic signed [DERR_W-1:0]  DERR_MIN  = {1'b1, {(DERR_W-1){1'b0}}};
  localparam logic signed [MOTOR_W-1:0] MOTOR_MAX = {1'b0, {(MOTOR_W-1){1'b1}}};
  localparam logic signed [MOTOR_W-1:0] MOTOR_MIN = {1'b1, {(MOTOR_W-1){1'b0}}};

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  logic [3:0] state_q, state_d;
  axis_t      ax_q;
  logic [2:0] mi_q;
  logic [1:0] ph_q;
  logic       out_valid_q;

  // configuration registers; mix gains kept in loop order
  logic [CFG_W-1:0] inv_dt_q;
  logic [CFG_W-1:0] gain_q [4];

  // loop history, reset to zero
  logic signed [ERR_W-1:0]  last_q [4];
  logic signed [HEAD_W-1:0] heading_q;

  // captured input item
  logic signed [STICK_W-1:0]  rs_q, ps_q, ys_q, ts_q;
  logic signed [ANGLE_W-1:0]  mr_q, mp_q, my_q;
  logic signed [HEIGHT_W-1:0] mh_q;

  // datapath
  logic signed [ERR_W-1:0]   err_q [4];
  logic signed [U_W-1:0]     u_q [4];
  logic signed [DERR_W-1:0]  derr_q;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [PROD_W-1:0]  prod_q [4];
  logic signed [MOTOR_W-1:0] motor_q [MOTOR_COUNT];

  logic in_fire, out_fire, cfg_fire;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_fire    = out_valid_q && out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  assign motor_0_o = motor_q[0];
  assign motor_1_o = motor_q[1];
  assign motor_2_o = motor_q[2];
  assign motor_3_o = motor_q[3];
  assign motor_4_o = motor_q[4];
  assign motor_5_o = motor_q[5];

  // --------------------------------------------------------------------------
  // Loop errors from the captured item
  // --------------------------------------------------------------------------
  logic signed [ERR_W-1:0]  e_roll, e_pitch, e_height, thr_lvl, e_yaw_raw, e_yaw;
  logic signed [24:0]       head_mul;
  logic signed [8:0]        head_step;
  logic signed [HEAD_W:0]   head_sum;
  logic signed [HEAD_W-1:0] head_next;

  always_comb begin
    e_roll  = (ERR_W'(rs_q) <<< 1) - (ERR_W'(mr_q) <<< 3);
    e_pitch = (ERR_W'(ps_q) <<< 1) + (ERR_W'(mp_q) <<< 3);

    // throttle mapped to 0..65535 by flipping the sign bit
    thr_lvl  = $signed(ERR_W'({~ts_q[STICK_W-1], ts_q[STICK_W-2:0]}));
    e_height = thr_lvl * THR_SCALE - (ERR_W'(mh_q) <<< 4);

    // heading advances by the rounded yaw stick step, then wraps around
    head_mul  = 25'(ys_q) * HEAD_STEP_MUL + HEAD_ROUND;
    head_step = head_mul[24:16];
    head_sum  = (HEAD_W+1)'(heading_q) + (HEAD_W+1)'(head_step);
    priority if (head_sum > HEADING_LIMIT) begin
      head_next = -HEADING_LIMIT;
    end else if (head_sum < -HEADING_LIMIT) begin
      head_next = HEADING_LIMIT;
    end else begin
      head_next = head_sum[HEAD_W-1:0];
    end

    // yaw error beyond the half-turn limit folds to a small fixed value
    e_yaw_raw = ERR_W'(heading_q) + (ERR_W'(my_q) <<< 3);
    priority if (e_yaw_raw > YAW_ERR_LIMIT) begin
      e_yaw = YAW_ERR_FOLD;
    end else if (e_yaw_raw < -YAW_ERR_LIMIT) begin
      e_yaw = -YAW_ERR_FOLD;
    end else begin
      e_yaw = e_yaw_raw;
    end
  end

  // --------------------------------------------------------------------------
  // Shared multiply-accumulate unit
  // --------------------------------------------------------------------------
  logic signed [OPD_W-1:0]   op_a, op_b, kp, kd;
  logic signed [2*OPD_W-1:0] mul_full;
  logic signed [ACC_W-1:0]   mul_w;
  logic signed [DIFF_W-1:0]  diff;

  always_comb begin
    unique case (ax_q)
      AX_ROLL, AX_PITCH: begin
        kp = KP_ATT;
        kd = KD_ATT;
      end
      AX_YAW: begin
        kp = KP_YAW;
        kd = KD_YAW;
      end
      AX_HEIGHT: begin
        kp = KP_ALT;
        kd = KD_ALT;
      end
      default: begin
        kp = KP_ATT;
        kd = KD_ATT;
      end
    endcase
  end

  assign diff = DIFF_W'(err_q[ax_q]) - DIFF_W'(last_q[ax_q]);

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_q)
      ST_DMUL: begin
        op_a = OPD_W'(diff);
        op_b = $signed({1'b0, inv_dt_q});
      end
      ST_PMUL: begin
        op_a = OPD_W'(err_q[ax_q]);
        op_b = kp;
      end
      ST_DMAC: begin
        op_a = OPD_W'(derr_q);
        op_b = kd;
      end
      ST_GAIN: begin
        op_a = OPD_W'(u_q[ax_q]);
        op_b = $signed({1'b0, gain_q[ax_q]});
      end
      default: ;
    endcase
  end

  assign mul_full = op_a * op_b;
  assign mul_w    = $signed(mul_full[ACC_W-1:0]);

  // --------------------------------------------------------------------------
  // Post-scaling of the accumulator
  // --------------------------------------------------------------------------
  logic signed [ACC_W-17:0]  acc_sh16;
  logic signed [ACC_W-18:0]  acc_sh17;
  logic signed [DERR_W-1:0]  derr_new;
  logic signed [U_W-1:0]     u_new, u_lo;
  logic signed [MOTOR_W-1:0] motor_new;

  always_comb begin
    acc_sh16 = acc_q[ACC_W-1:16];
    acc_sh17 = acc_q[ACC_W-1:17];

    // Saturating d_error keeps the clamped loop output unchanged: beyond this
    // range the kd term alone drives the output past its limit.
    priority if (acc_sh16 > DERR_MAX) begin
      derr_new = DERR_MAX;
    end else if (acc_sh16 < DERR_MIN) begin
      derr_new = DERR_MIN;
    end else begin
      derr_new = acc_sh16[DERR_W-1:0];
    end

    // thrust output is committed in the first gain cycle and floors at zero
    u_lo = (state_q == ST_GAIN) ? '0 : U_MIN;
    priority if (acc_sh16 > U_MAX) begin
      u_new = U_MAX;
    end else if (acc_sh16 < u_lo) begin
      u_new = u_lo;
    end else begin
      u_new = acc_sh16[U_W-1:0];
    end

    priority if (acc_sh17 > MOTOR_MAX) begin
      motor_new = MOTOR_MAX;
    end else if (acc_sh17 < MOTOR_MIN) begin
      motor_new = MOTOR_MIN;
    end else begin
      motor_new = acc_sh17[MOTOR_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Mixer terms and accumulator update
  // --------------------------------------------------------------------------
  logic signed [ACC_W-1:0] mix_base, mix_add;

  always_comb begin
    mix_base = (ph_q == PH_PITCH) ? mix_term(THRUST_TWICE, prod_q[AX_HEIGHT]) : acc_q;
    unique case (ph_q)
      PH_PITCH: mix_add = mix_term(PITCH_TWICE[mi_q], prod_q[AX_PITCH]);
      PH_ROLL:  mix_add = mix_term(ROLL_TWICE[mi_q], prod_q[AX_ROLL]);
      PH_YAW:   mix_add = mix_term(YAW_TWICE[mi_q], prod_q[AX_YAW]);
      default:  mix_add = '0;
    endcase
  end

  always_comb begin
    unique case (state_q)
      ST_DMUL, ST_PMUL: acc_d = mul_w;
      ST_DMAC:          acc_d = acc_q + mul_w;
      ST_MIX:           acc_d = mix_base + mix_add;
      default:          acc_d = acc_q;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_ERR;
      ST_ERR:  state_d = ST_YAW;
      ST_YAW:  state_d = ST_DMUL;
      ST_DMUL: state_d = ST_PMUL;
      ST_PMUL: state_d = ST_DMAC;
      ST_DMAC: state_d = (ax_q == AX_HEIGHT) ? ST_GAIN : ST_DMUL;
      ST_GAIN: if (ax_q == AX_HEIGHT) state_d = ST_WAIT;
      ST_WAIT: if (!out_valid_q) state_d = ST_MIX;
      ST_MIX:  if (ph_q == PH_YAW && mi_q == MOTOR_LAST) state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers, configuration and loop history
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ax_q        <= AX_ROLL;
      mi_q        <= '0;
      ph_q        <= PH_PITCH;
      out_valid_q <= 1'b0;
      inv_dt_q    <= INV_DT_RESET;
      for (int k = 0; k < 4; k++) begin
        gain_q[k] <= MIX_GAIN_RESET;
        last_q[k] <= '0;
      end
      heading_q   <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_fire) begin
        unique case (cfg_index_i)
          CFG_INV_DT: inv_dt_q          <= cfg_data_i;
          CFG_THRUST: gain_q[AX_HEIGHT] <= cfg_data_i;
          CFG_ROLL:   gain_q[AX_ROLL]   <= cfg_data_i;
          CFG_PITCH:  gain_q[AX_PITCH]  <= cfg_data_i;
          CFG_YAW:    gain_q[AX_YAW]    <= cfg_data_i;
          default: ;  // drop writes to unknown indexes
        endcase
      end

      // output slot: set on completion, clear on transfer
      if (state_q == ST_DONE) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_ERR:  heading_q <= head_next;
        ST_YAW:  ax_q <= AX_ROLL;
        ST_DMUL: last_q[ax_q] <= err_q[ax_q];
        ST_DMAC: ax_q <= (ax_q == AX_HEIGHT) ? AX_ROLL : ax_q + 2'd1;
        ST_GAIN: ax_q <= ax_q + 2'd1;
        ST_WAIT: begin
          mi_q <= '0;
          ph_q <= PH_PITCH;
        end
        ST_MIX: begin
          if (ph_q == PH_YAW) begin
            ph_q <= PH_PITCH;
            mi_q <= mi_q + 3'd1;
          end else begin
            ph_q <= ph_q + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rs_q <= roll_stick_i;
      ps_q <= pitch_stick_i;
      ys_q <= yaw_stick_i;
      ts_q <= throttle_stick_i;
      mr_q <= measured_roll_i;
      mp_q <= measured_pitch_i;
      my_q <= measured_yaw_i;
      mh_q <= measured_height_i;
    end

    acc_q <= acc_d;

    unique case (state_q)
      ST_ERR: begin
        err_q[AX_ROLL]   <= e_roll;
        err_q[AX_PITCH]  <= e_pitch;
        err_q[AX_HEIGHT] <= e_height;
      end
      ST_YAW:  err_q[AX_YAW] <= e_yaw;
      ST_DMUL: if (ax_q != AX_ROLL) u_q[ax_q - 2'd1] <= u_new;  // previous loop
      ST_PMUL: derr_q <= derr_new;
      ST_GAIN: begin
        if (ax_q == AX_ROLL) u_q[AX_HEIGHT] <= u_new;
        prod_q[ax_q] <= mul_w[PROD_W-1:0];
      end
      ST_MIX:  if (ph_q == PH_PITCH && mi_q != '0) motor_q[mi_q - 3'd1] <= motor_new;
      ST_DONE: motor_q[MOTOR_COUNT-1] <= motor_new;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // valid rises only when the last motor is stored
  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("out_valid rose outside completion");

  // held result must not be overwritten by the mixer
  a_mix_output_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MIX) |-> !out_valid_q)
    else $error("mixer writes while a result waits");

  a_motor_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MIX) |-> (mi_q <= MOTOR_LAST && ph_q <= PH_YAW))
    else $error("mixer index out of range");

  // loop outputs are clamped before mixing, thrust never negative
  a_thrust_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT) |-> (u_q[AX_HEIGHT] >= 0 && u_q[AX_HEIGHT] <= U_MAX))
    else $error("thrust loop output out of range");

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_YAW) |-> (heading_q <= HEADING_LIMIT && heading_q >= -HEADING_LIMIT))
    else $error("heading outside wrap limits");
`endif

endmodule

// ----- tb/hexacopter_pd_attitude_mixer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hexacopter_pd_attitude_mixer_tb - self-checking bench for the PD mixer
// Drives flight samples and register writes over valid/ready channels.
// Every accepted sample is run through a bit-exact fixed-point model of the
// four PD loops and the six-motor mix; motor commands are checked in order.
// ----------------------------------------------------------------------------
module hexacopter_pd_attitude_mixer_tb;
  import hexpdm_pkg::*;

  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 60;    // idle time after the last result has come out
  localparam int WATCHDOG_LIMIT = 4000;  // idle cycles without any transfer
  localparam int PRESSURE_HOLD  = 400;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 300;

  // Loop gains and limits, Q16.16
  localparam longint ATT_KP       = 8520;
  localparam longint ATT_KD       = 3932;
  localparam longint YAW_KP       = 9175;
  localparam longint YAW_KD       = 15729;
  localparam longint ALT_KP       = 20316;
  localparam longint ALT_KD       = 12452;
  localparam longint UNIT         = 65536;
  localparam longint HEADING_WRAP = 205128;
  localparam longint YAW_FOLD_AT  = 205783;
  localparam longint YAW_FOLD_TO  = 6554;
  localparam longint MOTOR_HI     = 64'sd2147483647;
  localparam longint MOTOR_LO     = -64'sd2147483648;

  typedef struct {
    logic signed [STICK_W-1:0]  roll_stick;
    logic signed [STICK_W-1:0]  pitch_stick;
    logic signed [STICK_W-1:0]  yaw_stick;
    logic signed [STICK_W-1:0]  throttle_stick;
    logic signed [ANGLE_W-1:0]  meas_roll;
    logic signed [ANGLE_W-1:0]  meas_pitch;
    logic signed [ANGLE_W-1:0]  meas_yaw;
    logic signed [HEIGHT_W-1:0] meas_height;
  } flight_sample_t;

  typedef logic [MOTOR_COUNT-1:0][MOTOR_W-1:0] motor_cmds_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                       clk_i  = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  cfg_idx_t                   cfg_index_i = '0;
  logic [CFG_W-1:0]           cfg_data_i  = '0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_ready_o;
  logic signed [STICK_W-1:0]  roll_stick_i      = '0;
  logic signed [STICK_W-1:0]  pitch_stick_i     = '0;
  logic signed [STICK_W-1:0]  yaw_stick_i       = '0;
  logic signed [STICK_W-1:0]  throttle_stick_i  = '0;
  logic signed [ANGLE_W-1:0]  measured_roll_i   = '0;
  logic signed [ANGLE_W-1:0]  measured_pitch_i  = '0;
  logic signed [ANGLE_W-1:0]  measured_yaw_i    = '0;
  logic signed [HEIGHT_W-1:0] measured_height_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [MOTOR_W-1:0]  motor_0_o, motor_1_o, motor_2_o;
  logic signed [MOTOR_W-1:0]  motor_3_o, motor_4_o, motor_5_o;

  hexacopter_pd_attitude_mixer u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .roll_stick_i     (roll_stick_i),
    .pitch_stick_i    (pitch_stick_i),
    .yaw_stick_i      (yaw_stick_i),
    .throttle_stick_i (throttle_stick_i),
    .measured_roll_i  (measured_roll_i),
    .measured_pitch_i (measured_pitch_i),
    .measured_yaw_i   (measured_yaw_i),
    .measured_height_i(measured_height_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .motor_0_o        (motor_0_o),
    .motor_1_o        (motor_1_o),
    .motor_2_o        (motor_2_o),
    .motor_3_o        (motor_3_o),
    .motor_4_o        (motor_4_o),
    .motor_5_o        (motor_5_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Controller model: register copies, loop history and heading
  // --------------------------------------------------------------------------
  longint step_rate   = longint'(INV_DT_RESET);
  longint thrust_gain = longint'(MIX_GAIN_RESET);
  longint roll_gain   = longint'(MIX_GAIN_RESET);
  longint pitch_gain  = longint'(MIX_GAIN_RESET);
  longint yaw_gain    = longint'(MIX_GAIN_RESET);
  longint err_hist [4] = '{0, 0, 0, 0};
  longint heading_est  = 0;

  motor_cmds_t pending_motor_cmds [$];
  int          mismatch_count = 0;

  bit steady_flow     = 1'b0;  // both sides run without gaps
  bit pressure_req    = 1'b0;
  bit pressure_served = 1'b0;

  // One PD loop: derivative scaled by 1/dt, both shifts floor, then clamp.
  function automatic longint pd_update(axis_t ax, longint err, longint kp, longint kd,
                                       longint floor_u);
    longint rate_term;
    longint u;
    rate_term    = ((err - err_hist[ax]) * step_rate) >>> 16;
    u            = (kp * err + kd * rate_term) >>> 16;
    err_hist[ax] = err;
    if (u > UNIT) u = UNIT;
    else if (u < floor_u) u = floor_u;
    return u;
  endfunction

  function automatic motor_cmds_t predict_motor_cmds(flight_sample_t s);
    motor_cmds_t cmds;
    longint      roll_u, pitch_u, yaw_u, thrust_u;
    longint      err, hdg, acc;
    longint      roll_dir, pitch_twice, yaw_dir;
    err     = 2 * longint'(s.roll_stick) - 8 * longint'(s.meas_roll);
    roll_u  = pd_update(AX_ROLL, err, ATT_KP, ATT_KD, -UNIT);
    err     = 2 * longint'(s.pitch_stick) + 8 * longint'(s.meas_pitch);
    pitch_u = pd_update(AX_PITCH, err, ATT_KP, ATT_KD, -UNIT);

    // Integrate the yaw stick at 0.001 per step (rounded), wrap at the limits
    hdg = heading_est + ((longint'(s.yaw_stick) * 131 + 32768) >>> 16);
    if (hdg > HEADING_WRAP) hdg = -HEADING_WRAP;
    else if (hdg < -HEADING_WRAP) hdg = HEADING_WRAP;
    heading_est = hdg;
    err = hdg + 8 * longint'(s.meas_yaw);
    if (err > YAW_FOLD_AT) err = YAW_FOLD_TO;
    else if (err < -YAW_FOLD_AT) err = -YAW_FOLD_TO;
    yaw_u = pd_update(AX_YAW, err, YAW_KP, YAW_KD, -UNIT);

    err      = 50 * (longint'(s.throttle_stick) + 32768) - 16 * longint'(s.meas_height);
    thrust_u = pd_update(AX_HEIGHT, err, ALT_KP, ALT_KD, 0);

    for (int m = 0; m < MOTOR_COUNT; m++) begin
      case (m)
        0:       begin roll_dir =  0; pitch_twice =  2; yaw_dir = -1; end
        1:       begin roll_dir = -1; pitch_twice =  1; yaw_dir =  1; end
        2:       begin roll_dir = -1; pitch_twice = -1; yaw_dir = -1; end
        3:       begin roll_dir =  0; pitch_twice = -2; yaw_dir =  1; end
        4:       begin roll_dir =  1; pitch_twice = -1; yaw_dir = -1; end
        default: begin roll_dir =  1; pitch_twice =  1; yaw_dir =  1; end
      endcase
      acc = 2 * thrust_u * thrust_gain
          + 2 * roll_dir * roll_u * roll_gain
          + pitch_twice * pitch_u * pitch_gain
          + 2 * yaw_dir * yaw_u * yaw_gain;
      acc = acc >>> 17;
      if (acc > MOTOR_HI) acc = MOTOR_HI;
      else if (acc < MOTOR_LO) acc = MOTOR_LO;
      cmds[m] = MOTOR_W'(acc);
    end
    return cmds;
  endfunction

  // --------------------------------------------------------------------------
  // Sample and gap generators
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int rand_span(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  // Largest (sel > 0), smallest (sel < 0) or zero value of a w-bit signed field
  function automatic longint bound(int w, int sel);
    if (sel > 0) return (longint'(1) <<< (w - 1)) - 1;
    if (sel < 0) return -(longint'(1) <<< (w - 1));
    return 0;
  endfunction

  function automatic flight_sample_t extreme_sample(int sel);
    flight_sample_t s;
    s.roll_stick     = STICK_W'(bound(STICK_W, sel));
    s.pitch_stick    = STICK_W'(bound(STICK_W, sel));
    s.yaw_stick      = STICK_W'(bound(STICK_W, sel));
    s.throttle_stick = STICK_W'(bound(STICK_W, sel));
    s.meas_roll      = ANGLE_W'(bound(ANGLE_W, sel));
    s.meas_pitch     = ANGLE_W'(bound(ANGLE_W, sel));
    s.meas_yaw       = ANGLE_W'(bound(ANGLE_W, sel));
    s.meas_height    = HEIGHT_W'(bound(HEIGHT_W, sel));
    return s;
  endfunction

  // Each field independently at its maximum, minimum or zero
  function automatic flight_sample_t corner_sample();
    flight_sample_t s;
    s.roll_stick     = STICK_W'(bound(STICK_W, rand_span(1)));
    s.pitch_stick    = STICK_W'(bound(STICK_W, rand_span(1)));
    s.yaw_stick      = STICK_W'(bound(STICK_W, rand_span(1)));
    s.throttle_stick = STICK_W'(bound(STICK_W, rand_span(1)));
    s.meas_roll      = ANGLE_W'(bound(ANGLE_W, rand_span(1)));
    s.meas_pitch     = ANGLE_W'(bound(ANGLE_W, rand_span(1)));
    s.meas_yaw       = ANGLE_W'(bound(ANGLE_W, rand_span(1)));
    s.meas_height    = HEIGHT_W'(bound(HEIGHT_W, rand_span(1)));
    return s;
  endfunction

  function automatic flight_sample_t noise_sample();
    flight_sample_t s;
    s.roll_stick     = STICK_W'($urandom);
    s.pitch_stick    = STICK_W'($urandom);
    s.yaw_stick      = STICK_W'($urandom);
    s.throttle_stick = STICK_W'($urandom);
    s.meas_roll      = ANGLE_W'($urandom);
    s.meas_pitch     = ANGLE_W'($urandom);
    s.meas_yaw       = ANGLE_W'($urandom);
    s.meas_height    = HEIGHT_W'($urandom);
    return s;
  endfunction

  // Near-hover flight: small attitude errors, yaw tracking the heading and
  // height close to the throttle target, so the loops stay off their clamps.
  function automatic flight_sample_t calm_sample();
    flight_sample_t s;
    s.roll_stick     = STICK_W'(rand_span(8192));
    s.pitch_stick    = STICK_W'(rand_span(8192));
    s.yaw_stick      = STICK_W'(rand_span(8192));
    s.throttle_stick = STICK_W'($urandom);
    s.meas_roll      = ANGLE_W'(rand_span(1024));
    s.meas_pitch     = ANGLE_W'(rand_span(1024));
    s.meas_yaw       = ANGLE_W'(-(heading_est >>> 3) + rand_span(512));
    s.meas_height    = HEIGHT_W'(((50 * (longint'(s.throttle_stick) + 32768)) >>> 4)
                                 + rand_span(256));
    return s;
  endfunction

  function automatic logic [CFG_W-1:0] pick_gain(int span_units);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 25) return '1;
    return CFG_W'($urandom_range(0, span_units << 16));
  endfunction

  // --------------------------------------------------------------------------
  // Channel drivers
  // --------------------------------------------------------------------------
  // Offer one sample after a random gap; hold valid high on back-to-back
  // transfers so valid never drops and rises within one step.
  task automatic send_sample(flight_sample_t s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    roll_stick_i      <= s.roll_stick;
    pitch_stick_i     <= s.pitch_stick;
    yaw_stick_i       <= s.yaw_stick;
    throttle_stick_i  <= s.throttle_stick;
    measured_roll_i   <= s.meas_roll;
    measured_pitch_i  <= s.meas_pitch;
    measured_yaw_i    <= s.meas_yaw;
    measured_height_i <= s.meas_height;
    do @(posedge clk_i); while (!in_ready_o);
    pending_motor_cmds.push_back(predict_motor_cmds(s));
  endtask

  // Drop valid, then wait until every expected command has come out.
  task automatic finish_batch();
    in_valid_i <= 1'b0;
    while (pending_motor_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register; only called while the block is idle.
  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_INV_DT: step_rate   = longint'(value);
      CFG_THRUST: thrust_gain = longint'(value);
      CFG_ROLL:   roll_gain   = longint'(value);
      CFG_PITCH:  pitch_gain  = longint'(value);
      CFG_YAW:    yaw_gain    = longint'(value);
      default:    ;  // unmapped index: the block drops the write
    endcase
    @(posedge clk_i);
  endtask

  task automatic load_defaults();
    write_reg(CFG_INV_DT, INV_DT_RESET);
    write_reg(CFG_THRUST, MIX_GAIN_RESET);
    write_reg(CFG_ROLL,   MIX_GAIN_RESET);
    write_reg(CFG_PITCH,  MIX_GAIN_RESET);
    write_reg(CFG_YAW,    MIX_GAIN_RESET);
  endtask

  // --------------------------------------------------------------------------
  // Result sink: random stalls, plus one long hold-off on request
  // --------------------------------------------------------------------------
  int sink_gap   = 0;
  int hold_count = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (pressure_req && !pressure_served) begin
      // hold off long enough for the block to fill and stall its input
      out_ready_i <= 1'b0;
      if (hold_count >= PRESSURE_HOLD) pressure_served <= 1'b1;
      hold_count <= hold_count + 1;
    end else if (sink_gap > 0) begin
      out_ready_i <= 1'b0;
      sink_gap    <= sink_gap - 1;
    end else begin
      out_ready_i <= 1'b1;
      sink_gap    <= pick_gap();
    end
  end

  // Compare each command transfer with the oldest prediction, motor by motor.
  always @(posedge clk_i) begin : check_results
    motor_cmds_t got;
    motor_cmds_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {motor_5_o, motor_4_o, motor_3_o, motor_2_o, motor_1_o, motor_0_o};
      if (pending_motor_cmds.size() == 0) begin
        $error("motor commands with no sample pending: %h", got);
        mismatch_count++;
      end else begin
        want = pending_motor_cmds.pop_front();
        for (int m = 0; m < MOTOR_COUNT; m++) begin
          if (got[m] !== want[m]) begin
            $error("motor_%0d: expected %0d, actual %0d", m,
                   $signed(want[m]), $signed(got[m]));
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog: end the run if nothing transfers for too long.
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Field extremes, yaw error folding both ways and both thrust clamps,
  // all at the reset register values.
  task automatic test_field_extremes();
    flight_sample_t s;
    send_sample(extreme_sample(0));
    send_sample(extreme_sample(1));
    send_sample(extreme_sample(-1));
    s = extreme_sample(-1);
    s.roll_stick     = STICK_W'(bound(STICK_W, 1));
    s.pitch_stick    = STICK_W'(bound(STICK_W, 1));
    s.yaw_stick      = STICK_W'(bound(STICK_W, 1));
    s.throttle_stick = STICK_W'(bound(STICK_W, 1));
    send_sample(s);
    s = extreme_sample(1);
    s.roll_stick     = STICK_W'(bound(STICK_W, -1));
    s.pitch_stick    = STICK_W'(bound(STICK_W, -1));
    s.yaw_stick      = STICK_W'(bound(STICK_W, -1));
    s.throttle_stick = STICK_W'(bound(STICK_W, -1));
    send_sample(s);
    // yaw error past +3.14 and past -3.14
    s = extreme_sample(0);
    s.meas_yaw = ANGLE_W'(bound(ANGLE_W, 1));
    send_sample(s);
    s.meas_yaw = ANGLE_W'(bound(ANGLE_W, -1));
    send_sample(s);
    // thrust pinned at zero, then at full
    s = extreme_sample(0);
    s.throttle_stick = STICK_W'(bound(STICK_W, -1));
    s.meas_height    = HEIGHT_W'(bound(HEIGHT_W, 1));
    send_sample(s);
    s.throttle_stick = STICK_W'(bound(STICK_W, 1));
    s.meas_height    = HEIGHT_W'(bound(HEIGHT_W, -1));
    send_sample(s);
    // step back to zero for a large derivative kick
    send_sample(extreme_sample(0));
    finish_batch();
  endtask

  task automatic test_zero_step_time();
    write_reg(CFG_INV_DT, '0);
    send_sample(extreme_sample(1));
    send_sample(extreme_sample(-1));
    send_sample(calm_sample());
    finish_batch();
    write_reg(CFG_INV_DT, INV_DT_RESET);
  endtask

  // Zero one mix gain at a time; that axis must drop out of every motor.
  task automatic test_zero_mix_gains();
    for (int idx = int'(CFG_THRUST); idx <= int'(CFG_YAW); idx++) begin
      write_reg(cfg_idx_t'(idx), '0);
      send_sample(corner_sample());
      finish_batch();
      write_reg(cfg_idx_t'(idx), MIX_GAIN_RESET);
    end
  endtask

  // Full-scale gains push the mix past the 32-bit limits.
  task automatic test_motor_saturation();
    write_reg(CFG_INV_DT, '1);
    write_reg(CFG_THRUST, '1);
    write_reg(CFG_ROLL,   '1);
    write_reg(CFG_PITCH,  '1);
    write_reg(CFG_YAW,    '1);
    send_sample(extreme_sample(1));
    send_sample(extreme_sample(-1));
    send_sample(corner_sample());
    send_sample(calm_sample());
    finish_batch();
    load_defaults();
  endtask

  // Writes to unmapped indexes must leave every register alone.
  task automatic test_unmapped_index();
    for (int idx = int'(CFG_YAW) + 1; idx < (1 << CFG_IDX_W); idx++)
      write_reg(cfg_idx_t'(idx), '0);
    send_sample(calm_sample());
    send_sample(corner_sample());
    finish_batch();
  endtask

  // Hold the sink off while the source keeps offering samples.
  task automatic test_output_backpressure();
    pressure_req <= 1'b1;
    repeat (12) send_sample(calm_sample());
    finish_batch();
  endtask

  // Random phases: reset gains, a phase with no idling, then random gains.
  task automatic test_random_traffic();
    int r;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      steady_flow <= (phase == 1);
      if (phase >= 2) begin
        write_reg(CFG_INV_DT, pick_gain(200));
        write_reg(CFG_THRUST, pick_gain(4));
        write_reg(CFG_ROLL,   pick_gain(4));
        write_reg(CFG_PITCH,  pick_gain(4));
        write_reg(CFG_YAW,    pick_gain(4));
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 60) send_sample(calm_sample());
        else if (r < 85) send_sample(noise_sample());
        else send_sample(corner_sample());
      end
      finish_batch();
    end
    steady_flow <= 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_field_extremes();
    test_zero_step_time();
    test_zero_mix_gains();
    test_motor_saturation();
    test_unmapped_index();
    test_output_backpressure();
    test_random_traffic();

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
